FILE: rtl/eabv_pkg.sv
package eabv_pkg;

	typedef struct packed {
		logic signed [15:0] pitch;
		logic signed [15:0] yaw;
		logic signed [15:0] roll;
	} req_t;

	typedef struct packed {
		logic signed [15:0] forward_x;
		logic signed [15:0] forward_y;
		logic signed [15:0] forward_z;
		logic signed [15:0] right_x;
		logic signed [15:0] right_y;
		logic signed [15:0] right_z;
		logic signed [15:0] up_x;
		logic signed [15:0] up_y;
		logic signed [15:0] up_z;
	} res_t;

	localparam logic [31:0] HALF_PI_Q31 = 32'hC90FDAA2;
	localparam logic [31:0] ONE_Q31 = 32'h8000_0000;

	// Taylor divisor k*(k+1)
	function automatic int unsigned div_of(input int unsigned k);
		return k * (k + 1);
	endfunction

	// reciprocal shift and value, rounded up; floor-exact for dividends below 2^31
	function automatic int unsigned rsh_of(input int unsigned d);
		return 31 + $clog2(d);
	endfunction

	function automatic logic [31:0] rcp_of(input int unsigned d);
		logic [63:0] num;
		num = 64'd1 << rsh_of(d);
		return 32'((num + 64'(d) - 64'd1) / 64'(d));
	endfunction

	// Q1.31 x Q1.31 rounded back to Q1.31, ties away from zero
	function automatic logic signed [33:0] mul_q31(input logic signed [33:0] a,
		input logic signed [33:0] b);
		logic signed [67:0] p;
		logic [67:0] m;
		logic [67:0] r;
		p = a * b;
		m = p[67] ? 68'(-p) : 68'(p);
		r = (m + (68'd1 << 30)) >> 31;
		return p[67] ? -34'(r) : 34'(r);
	endfunction

endpackage

FILE: rtl/eabv_sincos.sv
module eabv_sincos #(
	parameter int ANGLE_BITS = 16
) (
	input  logic               clk,
	input  logic signed [15:0] angle,
	output logic signed [33:0] sine,
	output logic signed [33:0] cosine
);
	import eabv_pkg::*;

	// Q1.31 outputs, fifteen stages: angle reduction, x squared, two stages per
	// Taylor term (times x^2, then reciprocal divide), quadrant fold
	localparam int TERMS = 6;
	localparam int STERMS = 5;
	localparam int LAST = 2 * TERMS + 2;

	logic [31:0] t;
	logic [29:0] r;
	logic        mir;
	logic [61:0] xp;
	logic [31:0] x_s1;
	logic [31:0] x2_s [2:2*TERMS];
	logic [31:0] st_s [2:2*STERMS+1];
	logic [31:0] ct_s [2:2*TERMS+1];
	logic [31:0] ss_s [2:LAST];
	logic [31:0] cs_s [2:LAST];
	logic [1:0]  q_s  [1:LAST];
	logic        m_s  [1:LAST];

	always_comb begin
		logic [31:0] ext;
		ext = 32'(signed'(angle));
		t = ANGLE_BITS >= 32 ? ext : ext << (32 - ANGLE_BITS);
		r = t[29:0];
		mir = r > 30'h2000_0000;
		xp = 62'(mir ? (31'h4000_0000 - {1'b0, r}) : {1'b0, r}) * 62'(HALF_PI_Q31);
	end

	always_ff @(posedge clk) begin
		x_s1 <= 32'(xp >> 30);
		q_s[1] <= t[31:30];
		m_s[1] <= mir;
	end

	always_ff @(posedge clk) begin
		x2_s[2] <= 32'((64'(x_s1) * 64'(x_s1)) >> 31);
		st_s[2] <= x_s1;
		ss_s[2] <= x_s1;
		ct_s[2] <= ONE_Q31;
		cs_s[2] <= ONE_Q31;
		q_s[2] <= q_s[1];
		m_s[2] <= m_s[1];
	end

	for (genvar n = 1; n <= TERMS; n++) begin : g_term
		localparam int IA = 2 * n + 1;
		localparam int IB = 2 * n + 2;
		localparam int unsigned DC = div_of(2 * n - 1);
		localparam logic [31:0] RC = rcp_of(DC);
		localparam int unsigned KC = rsh_of(DC);

		logic [31:0] cn;
		assign cn = 32'((64'(ct_s[IA]) * 64'(RC)) >> KC);

		always_ff @(posedge clk) begin
			ct_s[IA] <= 32'((64'(ct_s[IA-1]) * 64'(x2_s[IA-1])) >> 31);
			ss_s[IA] <= ss_s[IA-1];
			cs_s[IA] <= cs_s[IA-1];
			q_s[IA] <= q_s[IA-1];
			m_s[IA] <= m_s[IA-1];
		end

		always_ff @(posedge clk) begin
			if (n % 2 == 1) cs_s[IB] <= cs_s[IA] - cn;
			else cs_s[IB] <= cs_s[IA] + cn;
			q_s[IB] <= q_s[IA];
			m_s[IB] <= m_s[IA];
		end

		if (n < TERMS) begin : g_next
			always_ff @(posedge clk) begin
				ct_s[IB] <= cn;
				x2_s[IA] <= x2_s[IA-1];
				x2_s[IB] <= x2_s[IA];
			end
		end

		if (n <= STERMS) begin : g_sin
			localparam int unsigned DS = div_of(2 * n);
			localparam logic [31:0] RS = rcp_of(DS);
			localparam int unsigned KS = rsh_of(DS);

			logic [31:0] sn;
			assign sn = 32'((64'(st_s[IA]) * 64'(RS)) >> KS);

			always_ff @(posedge clk) begin
				st_s[IA] <= 32'((64'(st_s[IA-1]) * 64'(x2_s[IA-1])) >> 31);
			end

			always_ff @(posedge clk) begin
				if (n % 2 == 1) ss_s[IB] <= ss_s[IA] - sn;
				else ss_s[IB] <= ss_s[IA] + sn;
			end

			if (n < STERMS) begin : g_keep
				always_ff @(posedge clk) begin
					st_s[IB] <= sn;
				end
			end
		end else begin : g_sin_done
			always_ff @(posedge clk) begin
				ss_s[IB] <= ss_s[IA];
			end
		end
	end

	always_ff @(posedge clk) begin
		logic signed [33:0] a, b;
		a = 34'(m_s[LAST] ? cs_s[LAST] : ss_s[LAST]);
		b = 34'(m_s[LAST] ? ss_s[LAST] : cs_s[LAST]);
		case (q_s[LAST])
			2'd0: begin sine <= a; cosine <= b; end
			2'd1: begin sine <= b; cosine <= -a; end
			2'd2: begin sine <= -a; cosine <= -b; end
			default: begin sine <= -b; cosine <= a; end
		endcase
	end
endmodule

FILE: rtl/euler_angles_to_basis_vectors.sv
// Converts pitch, yaw and roll binary angles to forward, right and up unit vectors.
// One request per cycle, busy never rises; each result strobes on valid for one cycle,
// after fifteen sine/cosine stages, then two product stages and output rounding. The
// receiver cannot hold results off.
module euler_angles_to_basis_vectors #(
	parameter int ANGLE_BITS = 16,
	parameter int FRAC_BITS  = 14
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  eabv_pkg::req_t  req,
	output logic            valid,
	output eabv_pkg::res_t  res
);
	import eabv_pkg::*;

	localparam int LAT = 18;

	logic [LAT-1:0] vld_q;
	logic signed [33:0] sp, cp, sy, cy, sr, cr;
	logic signed [33:0] srsp_s1, crsp_s1, sp_s1, cp_s1, sy_s1, cy_s1, sr_s1, cr_s1;
	logic signed [33:0] v_s2 [9];

	assign busy = 1'b0;

	eabv_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_p (.clk,
		.angle(req.pitch), .sine(sp), .cosine(cp));
	eabv_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_y (.clk,
		.angle(req.yaw), .sine(sy), .cosine(cy));
	eabv_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_r (.clk,
		.angle(req.roll), .sine(sr), .cosine(cr));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else vld_q <= {vld_q[LAT-2:0], start};
	end

	always_ff @(posedge clk) begin
		srsp_s1 <= mul_q31(sr, sp);
		crsp_s1 <= mul_q31(cr, sp);
		{sp_s1, cp_s1, sy_s1, cy_s1, sr_s1, cr_s1} <= {sp, cp, sy, cy, sr, cr};
	end

	always_ff @(posedge clk) begin
		v_s2[0] <= mul_q31(cp_s1, cy_s1);
		v_s2[1] <= mul_q31(cp_s1, sy_s1);
		v_s2[2] <= -sp_s1;
		v_s2[3] <= mul_q31(cr_s1, sy_s1) - mul_q31(srsp_s1, cy_s1);
		v_s2[4] <= -mul_q31(srsp_s1, sy_s1) - mul_q31(cr_s1, cy_s1);
		v_s2[5] <= -mul_q31(sr_s1, cp_s1);
		v_s2[6] <= mul_q31(crsp_s1, cy_s1) + mul_q31(sr_s1, sy_s1);
		v_s2[7] <= mul_q31(crsp_s1, sy_s1) - mul_q31(sr_s1, cy_s1);
		v_s2[8] <= mul_q31(cr_s1, cp_s1);
	end

	function automatic logic [15:0] to_out(input logic signed [33:0] v);
		logic [33:0] m;
		logic [33:0] one;
		m = v[33] ? 34'(-v) : 34'(v);
		one = 34'd1 << FRAC_BITS;
		m = (m + (34'd1 << (30 - FRAC_BITS))) >> (31 - FRAC_BITS);
		if (m > one) m = one;
		return v[33] ? 16'(-m) : 16'(m);
	endfunction

	always_ff @(posedge clk) begin
		res <= {to_out(v_s2[0]), to_out(v_s2[1]), to_out(v_s2[2]), to_out(v_s2[3]),
			to_out(v_s2[4]), to_out(v_s2[5]), to_out(v_s2[6]), to_out(v_s2[7]),
			to_out(v_s2[8])};
	end

	assign valid = vld_q[LAT-1];

	a_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT valid) else $error("result lost");
	a_nospur: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> $past(vld_q[LAT-2])) else $error("spurious result");
endmodule

FILE: bench/euler_angles_to_basis_vectors_tb.sv
module euler_angles_to_basis_vectors_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import eabv_pkg::*;

	localparam int ANG_BITS = 16;
	localparam int FRAC = 14;
	localparam int LATENCY = 18;
	localparam longint CYCLE_LIMIT = 200000;
	localparam logic [63:0] HALF_PI = 64'hC90FDAA2;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic valid;
	req_t req = '0;
	res_t res;

	euler_angles_to_basis_vectors u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .valid(valid), .res(res)
	);

	always #6 clk = ~clk;

	res_t vectors_due[$];
	int errors = 0;
	longint cycles = 0;
	int idle_pct = 0;

	typedef struct {
		logic [15:0] p, y, r;
		bit known;
		res_t want;
	} row_t;

	function automatic longint round_q31(longint a, longint b);
		longint p;
		longint unsigned m;
		bit neg;
		p = a * b;
		neg = p < 0;
		m = neg ? -p : p;
		m = (m + (64'd1 << 30)) >> 31;
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic void taylor(input longint unsigned x, output longint unsigned s,
		output longint unsigned c);
		longint unsigned x2, term;
		x2 = (x * x) >> 31;
		term = x;
		s = x;
		for (int n = 1; n <= 5; n++) begin
			term = ((term * x2) >> 31) / ((2 * n) * (2 * n + 1));
			if (n & 1) s -= term; else s += term;
		end
		term = 64'd1 << 31;
		c = term;
		for (int n = 1; n <= 6; n++) begin
			term = ((term * x2) >> 31) / ((2 * n - 1) * (2 * n));
			if (n & 1) c -= term; else c += term;
		end
	endfunction

	function automatic void angle_sincos(input logic [15:0] ang, output longint s,
		output longint c);
		longint unsigned u, t, q, r, ss, cc, tmp;
		u = {{48{ang[15]}}, ang};
		u &= (64'd1 << ANG_BITS) - 1;
		t = (u << (32 - ANG_BITS)) & 64'hFFFF_FFFF;
		q = t >> 30;
		r = t & 64'h3FFF_FFFF;
		if (r > (64'd1 << 29)) begin
			taylor((((64'd1 << 30) - r) * HALF_PI) >> 30, ss, cc);
			tmp = ss; ss = cc; cc = tmp;
		end else begin
			taylor((r * HALF_PI) >> 30, ss, cc);
		end
		case (q)
			0: begin s = ss; c = cc; end
			1: begin s = cc; c = -longint'(ss); end
			2: begin s = -longint'(ss); c = -longint'(cc); end
			default: begin s = -longint'(cc); c = ss; end
		endcase
	endfunction

	function automatic logic [15:0] to_q214(longint v);
		longint unsigned m, one;
		bit neg;
		neg = v < 0;
		m = neg ? -v : v;
		one = 64'd1 << FRAC;
		m = (m + (64'd1 << (31 - FRAC - 1))) >> (31 - FRAC);
		if (m > one) m = one;
		return neg ? 16'(-m) : 16'(m);
	endfunction

	function automatic res_t basis_of(logic [15:0] p, logic [15:0] y, logic [15:0] r);
		longint sp, cp, sy, cy, sr, cr, srsp, crsp;
		res_t o;
		angle_sincos(p, sp, cp);
		angle_sincos(y, sy, cy);
		angle_sincos(r, sr, cr);
		srsp = round_q31(sr, sp);
		crsp = round_q31(cr, sp);
		o.forward_x = to_q214(round_q31(cp, cy));
		o.forward_y = to_q214(round_q31(cp, sy));
		o.forward_z = to_q214(-sp);
		o.right_x = to_q214(round_q31(cr, sy) - round_q31(srsp, cy));
		o.right_y = to_q214(-round_q31(srsp, sy) - round_q31(cr, cy));
		o.right_z = to_q214(-round_q31(sr, cp));
		o.up_x = to_q214(round_q31(crsp, cy) + round_q31(sr, sy));
		o.up_y = to_q214(round_q31(crsp, sy) - round_q31(sr, cy));
		o.up_z = to_q214(round_q31(cr, cp));
		return o;
	endfunction

	task automatic send(input logic [15:0] p, input logic [15:0] y, input logic [15:0] r);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req.pitch <= p;
		req.yaw <= y;
		req.roll <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		vectors_due.push_back(basis_of(p, y, r));
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("euler_angles_to_basis_vectors regression: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n && valid) begin
			if (vectors_due.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %h", res);
			end else begin
				want = vectors_due.pop_front();
				if (res !== want) begin
					errors++;
					if (errors <= 10) $display("mismatch: exp %h got %h", want, res);
				end
			end
		end
	end

	row_t rows[$];

	function automatic row_t mk(logic [15:0] p, logic [15:0] y, logic [15:0] r, bit k,
		res_t w);
		row_t t;
		t.p = p; t.y = y; t.r = r; t.known = k; t.want = w;
		return t;
	endfunction

	initial begin
		int wait_cycles;
		res_t zero_orient;
		zero_orient = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, -16'sd16384, 16'sd0,
			16'sd0, 16'sd0, 16'sd16384};
		rows.push_back(mk(16'h0000, 16'h0000, 16'h0000, 1, zero_orient));
		rows.push_back(mk(16'h4000, 16'h0000, 16'h0000, 0, '0));
		rows.push_back(mk(16'hC000, 16'h0000, 16'h0000, 0, '0));
		rows.push_back(mk(16'h8000, 16'h8000, 16'h8000, 0, '0));
		rows.push_back(mk(16'h7FFF, 16'h7FFF, 16'h7FFF, 0, '0));
		rows.push_back(mk(16'hFFFF, 16'hFFFF, 16'hFFFF, 0, '0));
		rows.push_back(mk(16'h0000, 16'h4000, 16'h0000, 0, '0));
		rows.push_back(mk(16'h0000, 16'h0000, 16'h4000, 0, '0));
		rows.push_back(mk(16'h2000, 16'h2000, 16'h2000, 0, '0));
		rows.push_back(mk(16'h2001, 16'h1FFF, 16'hE000, 0, '0));
		rows.push_back(mk(16'h6000, 16'hA000, 16'h5555, 0, '0));
		rows.push_back(mk(16'h0001, 16'h8001, 16'h3FFF, 0, '0));
		rows.push_back(mk(16'h5A5A, 16'hA5A5, 16'h1234, 0, '0));
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i]) begin
			send(rows[i].p, rows[i].y, rows[i].r);
			if (rows[i].known) vectors_due[$] = rows[i].want;
		end
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 0) ? 0 : (ph == 1) ? 84 : (ph == 2) ? 20 : 0;
			repeat (100) begin
				logic [15:0] p, y, r;
				p = 16'($urandom); y = 16'($urandom); r = 16'($urandom);
				if ($urandom_range(9) == 0) p = {2'($urandom_range(3)), 14'h0};
				if ($urandom_range(9) == 0) y = {3'($urandom_range(7)), 13'h0};
				send(p, y, r);
			end
		end
		start <= 1'b0;
		wait_cycles = 0;
		while (vectors_due.size() != 0 && wait_cycles < 1000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (LATENCY + 4) @(posedge clk);
		if (errors == 0 && vectors_due.size() == 0)
			$display("euler_angles_to_basis_vectors regression: pass");
		else
			$display("euler_angles_to_basis_vectors regression: fail");
		$finish;
	end
endmodule
